### sv/carp_pkg.sv
// Shared types, constants and codes of the cascaded angle/rate PID unit.
package carp_pkg;

   // Defaults of the top level parameters
   localparam int DEF_DRIVE_LIMIT  = 1000;
   localparam int DEF_SAMPLE_WIDTH = 16;

   // Fixed field widths
   localparam int GAIN_W     = 16;
   localparam int LIMIT_W    = 31;
   localparam int SUM_W      = 32;
   localparam int DRIVE_W    = 11;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // Fraction bits: Q8.8 samples, Q16.16 loop outputs
   localparam int TGT_SHIFT = 8;
   localparam int DRV_SHIFT = 16;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ANGLE_KP     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ANGLE_KI_DT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ANGLE_KD_DT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ANGLE_LIMIT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_RATE_KP      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_RATE_KI_DT   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_RATE_KD_DT   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_RATE_LIMIT   = 3'd7;

   // Register reset values
   localparam logic signed [GAIN_W-1:0] KP_RESET    = 16'sd256;
   localparam logic signed [GAIN_W-1:0] GAIN_ZERO   = 16'sd0;
   localparam logic [LIMIT_W-1:0]       LIMIT_RESET = 31'h7FFF_FFFF;

   // Datapath operations
   localparam int OP_W = 3;
   localparam logic [OP_W-1:0] OP_NONE = 3'd0; // hold
   localparam logic [OP_W-1:0] OP_LOAD = 3'd1; // latch item, angle error
   localparam logic [OP_W-1:0] OP_SUM  = 3'd2; // clamp sum, diff, kp product
   localparam logic [OP_W-1:0] OP_MI   = 3'd3; // ki product, start accumulator
   localparam logic [OP_W-1:0] OP_MD   = 3'd4; // kd product, accumulate
   localparam logic [OP_W-1:0] OP_ACC  = 3'd5; // accumulate last product
   localparam logic [OP_W-1:0] OP_TGT  = 3'd6; // rate target, rate error
   localparam logic [OP_W-1:0] OP_DRV  = 3'd7; // drive into result register

   // Loop select
   localparam logic LOOP_ANGLE = 1'b0;
   localparam logic LOOP_RATE  = 1'b1;

   typedef struct packed {
      logic            loop;
      logic [OP_W-1:0] op;
   } cmd_type;

endpackage

### sv/carp_ctrl.sv
// Sequencer of the cascaded PID unit: steps the shared datapath through both loops.
module carp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output carp_pkg::cmd_type cmd
);

   localparam int ST_W = 4;
   localparam logic [ST_W-1:0] ST_IDLE  = 4'd0;
   localparam logic [ST_W-1:0] ST_A_SUM = 4'd1;
   localparam logic [ST_W-1:0] ST_A_MI  = 4'd2;
   localparam logic [ST_W-1:0] ST_A_MD  = 4'd3;
   localparam logic [ST_W-1:0] ST_A_ACC = 4'd4;
   localparam logic [ST_W-1:0] ST_A_TGT = 4'd5;
   localparam logic [ST_W-1:0] ST_R_SUM = 4'd6;
   localparam logic [ST_W-1:0] ST_R_MI  = 4'd7;
   localparam logic [ST_W-1:0] ST_R_MD  = 4'd8;
   localparam logic [ST_W-1:0] ST_R_ACC = 4'd9;
   localparam logic [ST_W-1:0] ST_R_DRV = 4'd10;

   logic [ST_W-1:0] state_ff, state_in;
   logic            rsp_valid_ff, rsp_valid_in;

   // Decode state into datapath commands and next state
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.loop     = carp_pkg::LOOP_ANGLE;
      cmd.op       = carp_pkg::OP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = carp_pkg::OP_LOAD;
               state_in = ST_A_SUM;
            end
         end
         ST_A_SUM: begin
            cmd.op   = carp_pkg::OP_SUM;
            state_in = ST_A_MI;
         end
         ST_A_MI: begin
            cmd.op   = carp_pkg::OP_MI;
            state_in = ST_A_MD;
         end
         ST_A_MD: begin
            cmd.op   = carp_pkg::OP_MD;
            state_in = ST_A_ACC;
         end
         ST_A_ACC: begin
            cmd.op   = carp_pkg::OP_ACC;
            state_in = ST_A_TGT;
         end
         ST_A_TGT: begin
            cmd.op   = carp_pkg::OP_TGT;
            state_in = ST_R_SUM;
         end
         ST_R_SUM: begin
            cmd.loop = carp_pkg::LOOP_RATE;
            cmd.op   = carp_pkg::OP_SUM;
            state_in = ST_R_MI;
         end
         ST_R_MI: begin
            cmd.loop = carp_pkg::LOOP_RATE;
            cmd.op   = carp_pkg::OP_MI;
            state_in = ST_R_MD;
         end
         ST_R_MD: begin
            cmd.loop = carp_pkg::LOOP_RATE;
            cmd.op   = carp_pkg::OP_MD;
            state_in = ST_R_ACC;
         end
         ST_R_ACC: begin
            cmd.loop = carp_pkg::LOOP_RATE;
            cmd.op   = carp_pkg::OP_ACC;
            state_in = ST_R_DRV;
         end
         ST_R_DRV: begin
            cmd.loop = carp_pkg::LOOP_RATE;
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = carp_pkg::OP_DRV;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

### sv/carp_datapath.sv
// Datapath of the cascaded PID unit: registers, loop state, shared multiplier.
module carp_datapath #(
   parameter int DRIVE_LIMIT  = carp_pkg::DEF_DRIVE_LIMIT,
   parameter int SAMPLE_WIDTH = carp_pkg::DEF_SAMPLE_WIDTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  carp_pkg::cmd_type                    cmd,
   input  logic signed [SAMPLE_WIDTH-1:0]       req_set_angle,
   input  logic signed [SAMPLE_WIDTH-1:0]       req_actual_angle,
   input  logic signed [SAMPLE_WIDTH-1:0]       req_actual_rate,
   input  logic                                 csr_valid,
   input  logic [carp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [carp_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output logic signed [carp_pkg::DRIVE_W-1:0]  rsp_drive,
   output logic signed [SAMPLE_WIDTH-1:0]       rsp_rate_target
);

   localparam int GW     = carp_pkg::GAIN_W;
   localparam int LW     = carp_pkg::LIMIT_W;
   localparam int SW     = carp_pkg::SUM_W;
   localparam int ERR_W  = SAMPLE_WIDTH + 1;
   localparam int DIFF_W = SAMPLE_WIDTH + 2;
   localparam int OPND_W = (DIFF_W > SW + 2) ? DIFF_W : SW + 2;
   localparam int PROD_W = GW + OPND_W;
   localparam int ACC_W  = PROD_W + 2;

   localparam logic signed [ACC_W-1:0] SMAX =
      ACC_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
   localparam logic signed [ACC_W-1:0] SMIN = -SMAX - ACC_W'(1);
   localparam logic signed [ACC_W-1:0] DMAX = ACC_W'(DRIVE_LIMIT);
   localparam logic signed [ACC_W-1:0] DMIN = -DMAX;
   localparam logic signed [ACC_W-1:0] DBIAS =
      ACC_W'((64'sd1 <<< carp_pkg::DRV_SHIFT) - 64'sd1);

   // Configuration registers
   logic signed [GW-1:0] angle_kp_ff, angle_ki_ff, angle_kd_ff;
   logic signed [GW-1:0] rate_kp_ff, rate_ki_ff, rate_kd_ff;
   logic [LW-1:0]        angle_lim_ff, rate_lim_ff;

   // Loop state
   logic signed [SW-1:0]    angle_sum_ff, angle_sum_in, rate_sum_ff, rate_sum_in;
   logic signed [ERR_W-1:0] angle_last_ff, angle_last_in, rate_last_ff, rate_last_in;

   // Working registers
   logic signed [ERR_W-1:0]        err_ff, err_in;
   logic signed [DIFF_W-1:0]       diff_ff, diff_in;
   logic signed [SAMPLE_WIDTH-1:0] rate_ff, rate_in;
   logic signed [SAMPLE_WIDTH-1:0] tgt_ff, tgt_in;
   logic signed [PROD_W-1:0]       prod_ff, prod_in;
   logic signed [ACC_W-1:0]        acc_ff, acc_in;
   logic signed [carp_pkg::DRIVE_W-1:0] drive_ff, drive_in;
   logic signed [SAMPLE_WIDTH-1:0] rtgt_ff, rtgt_in;

   // Per-loop selections
   logic signed [GW-1:0]     kp_sel, ki_sel, kd_sel, gain_sel;
   logic [LW-1:0]            lim_sel;
   logic signed [SW-1:0]     sum_sel;
   logic signed [ERR_W-1:0]  last_sel;
   logic signed [OPND_W-1:0] opnd_sel;

   // Sum clamp, target and drive terms
   logic signed [OPND_W-1:0] sum_raw, lim_pos, lim_neg, sum_clamp;
   logic signed [ACC_W-1:0]  tgt_shift, tgt_sat, drv_shift, drv_sat;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         angle_kp_ff  <= carp_pkg::KP_RESET;
         angle_ki_ff  <= carp_pkg::GAIN_ZERO;
         angle_kd_ff  <= carp_pkg::GAIN_ZERO;
         angle_lim_ff <= carp_pkg::LIMIT_RESET;
         rate_kp_ff   <= carp_pkg::KP_RESET;
         rate_ki_ff   <= carp_pkg::GAIN_ZERO;
         rate_kd_ff   <= carp_pkg::GAIN_ZERO;
         rate_lim_ff  <= carp_pkg::LIMIT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            carp_pkg::REG_ANGLE_KP:    angle_kp_ff  <= csr_wdata[GW-1:0];
            carp_pkg::REG_ANGLE_KI_DT: angle_ki_ff  <= csr_wdata[GW-1:0];
            carp_pkg::REG_ANGLE_KD_DT: angle_kd_ff  <= csr_wdata[GW-1:0];
            carp_pkg::REG_ANGLE_LIMIT: angle_lim_ff <= csr_wdata[LW-1:0];
            carp_pkg::REG_RATE_KP:     rate_kp_ff   <= csr_wdata[GW-1:0];
            carp_pkg::REG_RATE_KI_DT:  rate_ki_ff   <= csr_wdata[GW-1:0];
            carp_pkg::REG_RATE_KD_DT:  rate_kd_ff   <= csr_wdata[GW-1:0];
            carp_pkg::REG_RATE_LIMIT:  rate_lim_ff  <= csr_wdata[LW-1:0];
            default: ;
         endcase
      end
   end

   // Select the active loop's gains and state
   always_comb begin
      if (cmd.loop == carp_pkg::LOOP_RATE) begin
         kp_sel   = rate_kp_ff;
         ki_sel   = rate_ki_ff;
         kd_sel   = rate_kd_ff;
         lim_sel  = rate_lim_ff;
         sum_sel  = rate_sum_ff;
         last_sel = rate_last_ff;
      end else begin
         kp_sel   = angle_kp_ff;
         ki_sel   = angle_ki_ff;
         kd_sel   = angle_kd_ff;
         lim_sel  = angle_lim_ff;
         sum_sel  = angle_sum_ff;
         last_sel = angle_last_ff;
      end
   end

   // Shared multiplier operands
   always_comb begin
      case (cmd.op)
         carp_pkg::OP_MI: begin
            gain_sel = ki_sel;
            opnd_sel = OPND_W'(sum_sel);
         end
         carp_pkg::OP_MD: begin
            gain_sel = kd_sel;
            opnd_sel = OPND_W'(diff_ff);
         end
         default: begin
            gain_sel = kp_sel;
            opnd_sel = OPND_W'(err_ff);
         end
      endcase
   end

   assign prod_in = gain_sel * opnd_sel;

   // Add the error into the sum and clamp it symmetrically
   always_comb begin
      sum_raw = OPND_W'(sum_sel) + OPND_W'(err_ff);
      lim_pos = $signed({{(OPND_W - LW){1'b0}}, lim_sel});
      lim_neg = -lim_pos;
      if (sum_raw > lim_pos) begin
         sum_clamp = lim_pos;
      end else if (sum_raw < lim_neg) begin
         sum_clamp = lim_neg;
      end else begin
         sum_clamp = sum_raw;
      end
   end

   // Floor to Q8.8 and saturate the rate target
   always_comb begin
      tgt_shift = acc_ff >>> carp_pkg::TGT_SHIFT;
      if (tgt_shift > SMAX) begin
         tgt_sat = SMAX;
      end else if (tgt_shift < SMIN) begin
         tgt_sat = SMIN;
      end else begin
         tgt_sat = tgt_shift;
      end
   end

   // Truncate the drive toward zero and saturate it
   always_comb begin
      drv_shift = (acc_ff + (acc_ff[ACC_W-1] ? DBIAS : ACC_W'(0))) >>> carp_pkg::DRV_SHIFT;
      if (drv_shift > DMAX) begin
         drv_sat = DMAX;
      end else if (drv_shift < DMIN) begin
         drv_sat = DMIN;
      end else begin
         drv_sat = drv_shift;
      end
   end

   // Next values of the working and loop registers
   always_comb begin
      err_in        = err_ff;
      diff_in       = diff_ff;
      rate_in       = rate_ff;
      tgt_in        = tgt_ff;
      acc_in        = acc_ff;
      drive_in      = drive_ff;
      rtgt_in       = rtgt_ff;
      angle_sum_in  = angle_sum_ff;
      rate_sum_in   = rate_sum_ff;
      angle_last_in = angle_last_ff;
      rate_last_in  = rate_last_ff;
      case (cmd.op)
         carp_pkg::OP_LOAD: begin
            err_in  = ERR_W'(req_set_angle) - ERR_W'(req_actual_angle);
            rate_in = req_actual_rate;
         end
         carp_pkg::OP_SUM: begin
            diff_in = DIFF_W'(err_ff) - DIFF_W'(last_sel);
            if (cmd.loop == carp_pkg::LOOP_RATE) begin
               rate_sum_in  = sum_clamp[SW-1:0];
               rate_last_in = err_ff;
            end else begin
               angle_sum_in  = sum_clamp[SW-1:0];
               angle_last_in = err_ff;
            end
         end
         carp_pkg::OP_MI: begin
            acc_in = ACC_W'(prod_ff);
         end
         carp_pkg::OP_MD, carp_pkg::OP_ACC: begin
            acc_in = acc_ff + ACC_W'(prod_ff);
         end
         carp_pkg::OP_TGT: begin
            tgt_in = tgt_sat[SAMPLE_WIDTH-1:0];
            err_in = ERR_W'($signed(tgt_sat[SAMPLE_WIDTH-1:0])) - ERR_W'(rate_ff);
         end
         carp_pkg::OP_DRV: begin
            drive_in = drv_sat[carp_pkg::DRIVE_W-1:0];
            rtgt_in  = tgt_ff;
         end
         default: ;
      endcase
   end

   // Loop state clears on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         angle_sum_ff  <= '0;
         rate_sum_ff   <= '0;
         angle_last_ff <= '0;
         rate_last_ff  <= '0;
      end else begin
         angle_sum_ff  <= angle_sum_in;
         rate_sum_ff   <= rate_sum_in;
         angle_last_ff <= angle_last_in;
         rate_last_ff  <= rate_last_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      err_ff   <= err_in;
      diff_ff  <= diff_in;
      rate_ff  <= rate_in;
      tgt_ff   <= tgt_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      drive_ff <= drive_in;
      rtgt_ff  <= rtgt_in;
   end

   assign rsp_drive       = drive_ff;
   assign rsp_rate_target = rtgt_ff;

endmodule

### sv/cascaded_angle_rate_pid_unit.sv
// Cascaded angle/rate PID unit: top level joining sequencer and datapath.
// The result is registered in the drive step, the last of the rate loop's steps after an item is accepted.
// A new item is taken only once the sequencer is idle again; the single shared multiplier
// forms three products per loop, two loops in series, one step per cycle unless a result stalls.
// A stalled result holds the sequencer in its last step until the result is taken.
// Reset (synchronous): configuration registers return to their defaults, error sums and last errors clear.
module cascaded_angle_rate_pid_unit #(
   parameter int DRIVE_LIMIT  = carp_pkg::DEF_DRIVE_LIMIT,
   parameter int SAMPLE_WIDTH = carp_pkg::DEF_SAMPLE_WIDTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0]       req_set_angle,
   input  logic signed [SAMPLE_WIDTH-1:0]       req_actual_angle,
   input  logic signed [SAMPLE_WIDTH-1:0]       req_actual_rate,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [carp_pkg::DRIVE_W-1:0]  rsp_drive,
   output logic signed [SAMPLE_WIDTH-1:0]       rsp_rate_target,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [carp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [carp_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   carp_pkg::cmd_type cmd;

   // Registers take a write in every cycle
   assign csr_ready = 1'b1;

   carp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   carp_datapath #(
      .DRIVE_LIMIT  (DRIVE_LIMIT),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_set_angle    (req_set_angle),
      .req_actual_angle (req_actual_angle),
      .req_actual_rate  (req_actual_rate),
      .csr_valid        (csr_valid && csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_drive        (rsp_drive),
      .rsp_rate_target  (rsp_rate_target)
   );

`ifndef SYNTHESIS
   // An accepted item keeps the unit busy in the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("unit ready right after accepting an item");

   // Writing the drive always presents a result
   a_drive_presents: assert property (@(posedge clock) disable iff (reset)
      cmd.op == carp_pkg::OP_DRV |=> rsp_valid)
      else $error("drive step did not present a result");

   // The drive step never overwrites a result still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.op == carp_pkg::OP_DRV |-> !rsp_valid || rsp_ready)
      else $error("result overwritten before it was taken");

   // A presented drive stays within its limit
   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (DRIVE_LIMIT < 1024) |->
         ($signed(rsp_drive) <= DRIVE_LIMIT) && ($signed(rsp_drive) >= -DRIVE_LIMIT))
      else $error("drive out of range");
`endif

endmodule
